// ----- sv/bitstream_header_stripper_defines.svh -----
// Shared assertion macros for the header stripper.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BITSTREAM_HEADER_STRIPPER_DEFINES_SVH
`define BITSTREAM_HEADER_STRIPPER_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define BHS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bhs assertion failed");

// When the first condition holds, the second holds in the same cycle.
`define BHS_ASSERT_IMPLY(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bhs assertion failed");

// When the first condition holds, the second holds in the next cycle.
`define BHS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bhs assertion failed");

`endif

// ----- sv/bhs_pkg.sv -----
package bhs_pkg;

    // Result classification of one byte.
    typedef enum logic [2:0]
    {
        KIND_HEADER  = 3'd0,
        KIND_PAYLOAD = 3'd1,
        KIND_EXTRA   = 3'd2,
        KIND_BADKEY  = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    // Parser phase within a field, one-hot.
    typedef enum logic [7:0]
    {
        PH_LEN_HI  = 8'b0000_0001,
        PH_LEN_LO  = 8'b0000_0010,
        PH_BODY    = 8'b0000_0100,
        PH_KEY     = 8'b0000_1000,
        PH_BITLEN0 = 8'b0001_0000,
        PH_BITLEN1 = 8'b0010_0000,
        PH_BITLEN2 = 8'b0100_0000,
        PH_BITLEN3 = 8'b1000_0000
    } phase_t;

    localparam logic [2:0] FIRST_KEYED_FIELD = 3'd3;
    localparam logic [2:0] PAYLOAD_FIELD     = 3'd6;

    // One input item.
    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       first_byte;
    } item_t;

    // One result item.
    typedef struct packed
    {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [2:0]  field_number;
        logic [31:0] remaining_length;
        logic [31:0] extra_count;
    } result_t;

    // Expected key byte for a keyed field.
    function automatic logic [7:0] key_for_field(input logic [2:0] field);
        logic [7:0] key;
        case (field)
            3'd3:    key = 8'h62;   // 'b'
            3'd4:    key = 8'h63;   // 'c'
            3'd5:    key = 8'h64;   // 'd'
            3'd6:    key = 8'h65;   // 'e'
            default: key = 8'h62;
        endcase
        return key;
    endfunction

endpackage

// ----- sv/bhs_parser.sv -----
`include "bitstream_header_stripper_defines.svh"

module bhs_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  bhs_pkg::item_t  item,
    output bhs_pkg::result_t result
);
    import bhs_pkg::*;

    logic [2:0]  field_index_reg, field_index_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] skip_count_reg, skip_count_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [31:0] beyond_reg, beyond_next;
    logic        error_reg, error_next;

    logic [2:0]  cur_field;
    phase_t      cur_phase;
    logic [15:0] cur_skip;
    logic [31:0] cur_remaining;
    logic [31:0] cur_beyond;
    logic        cur_error;
    logic [7:0]  b;
    logic [2:0]  field_inc;
    logic [15:0] skip_len;
    logic [15:0] skip_dec;
    logic [31:0] remaining_shift;
    logic        in_payload_field;
    kind_t       kind;

    // State as seen by this item: a first byte starts from the reset values.
    always_comb
    begin
        b = item.data_byte;
        if (item.first_byte)
        begin
            cur_field     = 3'd0;
            cur_phase     = PH_LEN_HI;
            cur_skip      = 16'd0;
            cur_remaining = 32'd0;
            cur_beyond    = 32'd0;
            cur_error     = 1'b0;
        end
        else
        begin
            cur_field     = (field_index_reg > PAYLOAD_FIELD) ? PAYLOAD_FIELD
                                                              : field_index_reg;
            cur_phase     = phase_reg;
            cur_skip      = skip_count_reg;
            cur_remaining = remaining_reg;
            cur_beyond    = beyond_reg;
            cur_error     = error_reg;
        end
        in_payload_field = (cur_field == PAYLOAD_FIELD);
        field_inc        = cur_field + 3'd1;
        skip_len         = {cur_skip[15:8], b};
        skip_dec         = cur_skip - {15'd0, (cur_skip != 16'd0)};
        remaining_shift  = {cur_remaining[23:0], b};
    end

    // Next state and result kind for the current item.
    always_comb
    begin
        field_index_next = cur_field;
        phase_next       = cur_phase;
        skip_count_next  = cur_skip;
        remaining_next   = cur_remaining;
        beyond_next      = cur_beyond;
        error_next       = cur_error;
        kind             = KIND_HEADER;

        if (cur_error)
        begin
            kind = KIND_IGNORED;
        end
        else
        begin
            case (cur_phase)
                PH_LEN_HI:
                begin
                    if (in_payload_field)
                    begin
                        if (cur_remaining != 32'd0)
                        begin
                            remaining_next = cur_remaining - 32'd1;
                            kind           = KIND_PAYLOAD;
                        end
                        else
                        begin
                            if (cur_beyond != 32'hFFFF_FFFF)
                            begin
                                beyond_next = cur_beyond + 32'd1;
                            end
                            kind = KIND_EXTRA;
                        end
                    end
                    else
                    begin
                        skip_count_next = {b, 8'h00};
                        phase_next      = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    if (in_payload_field)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else if (skip_len == 16'd0)
                    begin
                        field_index_next = field_inc;
                        phase_next       = (field_inc < FIRST_KEYED_FIELD) ? PH_LEN_HI
                                                                           : PH_KEY;
                        skip_count_next  = 16'd0;
                    end
                    else
                    begin
                        skip_count_next = skip_len;
                        phase_next      = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    if (in_payload_field)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else if (skip_dec == 16'd0)
                    begin
                        field_index_next = field_inc;
                        phase_next       = (field_inc < FIRST_KEYED_FIELD) ? PH_LEN_HI
                                                                           : PH_KEY;
                        skip_count_next  = 16'd0;
                    end
                    else
                    begin
                        skip_count_next = skip_dec;
                    end
                end
                PH_KEY:
                begin
                    if (cur_field >= FIRST_KEYED_FIELD && b == key_for_field(cur_field))
                    begin
                        phase_next = in_payload_field ? PH_BITLEN0 : PH_LEN_HI;
                    end
                    else
                    begin
                        error_next = 1'b1;
                        kind       = KIND_BADKEY;
                    end
                end
                PH_BITLEN0:
                begin
                    remaining_next = remaining_shift;
                    phase_next     = in_payload_field ? PH_BITLEN1 : PH_LEN_HI;
                end
                PH_BITLEN1:
                begin
                    remaining_next = remaining_shift;
                    phase_next     = in_payload_field ? PH_BITLEN2 : PH_LEN_HI;
                end
                PH_BITLEN2:
                begin
                    remaining_next = remaining_shift;
                    phase_next     = in_payload_field ? PH_BITLEN3 : PH_LEN_HI;
                end
                PH_BITLEN3:
                begin
                    remaining_next = remaining_shift;
                    phase_next     = PH_LEN_HI;
                end
                default:
                begin
                    phase_next = PH_LEN_HI;
                end
            endcase
        end
    end

    // Result fields: the field number as seen by this item; remaining length and extra count after it.
    always_comb
    begin
        result.kind             = kind;
        result.out_byte         = b;
        result.field_number     = cur_field;
        result.remaining_length = remaining_next;
        result.extra_count      = beyond_next;
    end

    // Parser state advances once per item taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg <= 3'd0;
            phase_reg       <= PH_LEN_HI;
            skip_count_reg  <= 16'd0;
            remaining_reg   <= 32'd0;
            beyond_reg      <= 32'd0;
            error_reg       <= 1'b0;
        end
        else if (take)
        begin
            field_index_reg <= field_index_next;
            phase_reg       <= phase_next;
            skip_count_reg  <= skip_count_next;
            remaining_reg   <= remaining_next;
            beyond_reg      <= beyond_next;
            error_reg       <= error_next;
        end
    end

    `BHS_ASSERT_ALWAYS(a_field_range, field_index_reg <= PAYLOAD_FIELD)
    `BHS_ASSERT_IMPLY(a_bitlen_in_payload, phase_reg == PH_BITLEN0 || phase_reg == PH_BITLEN1 || phase_reg == PH_BITLEN2 || phase_reg == PH_BITLEN3, field_index_reg == PAYLOAD_FIELD)
    `BHS_ASSERT_IMPLY(a_skip_only_in_len, skip_count_reg != 16'd0, phase_reg == PH_LEN_LO || phase_reg == PH_BODY)
    `BHS_ASSERT_NEXT(a_error_sticky, error_reg && !(take && item.first_byte), error_reg)
    `BHS_ASSERT_NEXT(a_extra_saturates, beyond_reg == 32'hFFFF_FFFF && !(take && item.first_byte), beyond_reg == 32'hFFFF_FFFF)

endmodule

// ----- sv/bitstream_header_stripper.sv -----
// Configuration-file header stripper. Bytes of the file enter one per item;
// first_byte restarts the parser for a new file. Every item yields exactly one
// result item that classifies the byte (header, payload within the declared
// length, payload beyond it, bad key, ignored after an error) and reports the
// field, remaining bitstream length and saturating extra count. An item
// passes through the input register and then the result register; the parser
// classifies each byte combinationally between them, so one item per clock
// is sustained when the result side does not stall.
module bitstream_header_stripper
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  field_number,
    output logic [31:0] remaining_length,
    output logic [31:0] extra_count
);
    import bhs_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;
    result_t parsed;
    logic    in_take;
    logic    advance;

    // The held item moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    bhs_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .item   (in_item_reg),
        .result (parsed)
    );

    // Valid flags of the input and result registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.data_byte  <= data_byte;
            in_item_reg.first_byte <= first_byte;
        end
        if (advance)
        begin
            out_result_reg <= parsed;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = out_result_reg.kind;
    assign out_byte         = out_result_reg.out_byte;
    assign field_number     = out_result_reg.field_number;
    assign remaining_length = out_result_reg.remaining_length;
    assign extra_count      = out_result_reg.extra_count;

endmodule

// ----- tb/bitstream_header_stripper_tb.sv -----
`timescale 1ns / 100ps

module bitstream_header_stripper_tb;

    import bhs_pkg::*;

    // Key letters of the keyed fields, 'b' through 'e'.
    localparam logic [7:0] KEY_B = 8'h62;
    localparam logic [7:0] KEY_C = 8'h63;
    localparam logic [7:0] KEY_D = 8'h64;
    localparam logic [7:0] KEY_E = 8'h65;

    localparam int RUN_LIMIT_NS = 5_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [2:0]  field_number;
    logic [31:0] remaining_length;
    logic [31:0] extra_count;

    // Parser state mirrored by the testbench, cleared like the block's reset.
    logic [2:0]  cur_field = 3'd0;
    phase_t      cur_phase = PH_LEN_HI;
    logic [15:0] bytes_to_skip = 16'd0;
    logic [31:0] bitstream_left = 32'd0;
    logic [31:0] overrun_count = 32'd0;
    bit          parse_failed = 1'b0;

    result_t     pending_byte_results[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          sender_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          stall_hold_left = 0;

    // File builder state: the next byte opens a file, and a truncated file
    // stops once its byte budget is spent.
    bit          new_file = 1'b0;
    int          file_bytes_left = 0;

    bitstream_header_stripper u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .first_byte       (first_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .out_byte         (out_byte),
        .field_number     (field_number),
        .remaining_length (remaining_length),
        .extra_count      (extra_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Step into the next field; keyed fields open with their key byte.
    function automatic void advance_field();
        cur_field = cur_field + 3'd1;
        cur_phase = (cur_field < FIRST_KEYED_FIELD) ? PH_LEN_HI : PH_KEY;
        bytes_to_skip = 16'd0;
    endfunction

    // Classify one file byte and update the mirrored parser state.
    function automatic result_t parse_header_byte(input logic [7:0] b, input logic restart);
        result_t    r;
        logic [7:0] want_key;
        if (restart)
        begin
            cur_field = 3'd0;
            cur_phase = PH_LEN_HI;
            bytes_to_skip = 16'd0;
            bitstream_left = 32'd0;
            overrun_count = 32'd0;
            parse_failed = 1'b0;
        end
        if (cur_field > PAYLOAD_FIELD)
            cur_field = PAYLOAD_FIELD;
        r.kind = KIND_HEADER;
        r.out_byte = b;
        r.field_number = cur_field;

        if (parse_failed)
            r.kind = KIND_IGNORED;
        else if (cur_field == PAYLOAD_FIELD && cur_phase == PH_LEN_HI)
        begin
            // Payload counts down the declared length, then counts overrun.
            if (bitstream_left != 32'd0)
            begin
                bitstream_left = bitstream_left - 32'd1;
                r.kind = KIND_PAYLOAD;
            end
            else
            begin
                if (overrun_count != 32'hFFFF_FFFF)
                    overrun_count = overrun_count + 32'd1;
                r.kind = KIND_EXTRA;
            end
        end
        else if (cur_phase == PH_KEY)
        begin
            want_key = KEY_B + {5'd0, cur_field - FIRST_KEYED_FIELD};
            if (cur_field >= FIRST_KEYED_FIELD && b == want_key)
                cur_phase = (cur_field == PAYLOAD_FIELD) ? PH_BITLEN0 : PH_LEN_HI;
            else
            begin
                parse_failed = 1'b1;
                r.kind = KIND_BADKEY;
            end
        end
        else if (cur_phase == PH_BITLEN0 || cur_phase == PH_BITLEN1 ||
                 cur_phase == PH_BITLEN2 || cur_phase == PH_BITLEN3)
        begin
            // Bitstream length arrives big-endian, one byte per item.
            bitstream_left = {bitstream_left[23:0], b};
            if (cur_phase == PH_BITLEN3 || cur_field != PAYLOAD_FIELD)
                cur_phase = PH_LEN_HI;
            else
                cur_phase = phase_t'(cur_phase << 1);
        end
        else if (cur_field == PAYLOAD_FIELD)
            cur_phase = PH_LEN_HI;
        else if (cur_phase == PH_LEN_HI)
        begin
            bytes_to_skip = {b, 8'h00};
            cur_phase = PH_LEN_LO;
        end
        else if (cur_phase == PH_LEN_LO)
        begin
            bytes_to_skip = bytes_to_skip | {8'h00, b};
            if (bytes_to_skip == 16'd0)
                advance_field();
            else
                cur_phase = PH_BODY;
        end
        else
        begin
            // Body byte of a skipped field.
            if (bytes_to_skip != 16'd0)
                bytes_to_skip = bytes_to_skip - 16'd1;
            if (bytes_to_skip == 16'd0)
                advance_field();
        end

        r.remaining_length = bitstream_left;
        r.extra_count = overrun_count;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Offer one item, hold it until accepted, and record its expected result.
    task automatic send_byte(input logic [7:0] value, input logic restart);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        first_byte <= restart;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_byte_results.push_back(parse_header_byte(value, restart));
        items_sent++;
        @(negedge clk);
    endtask

    // Send the next byte of the current file, marking the first one.
    task automatic put(input logic [7:0] value);
        if (file_bytes_left != 0)
        begin
            send_byte(value, new_file);
            new_file = 1'b0;
            file_bytes_left--;
        end
    endtask

    task automatic open_file();
        new_file = 1'b1;
        file_bytes_left = 1 << 30;
    endtask

    // Hold the sender until every outstanding result has been checked.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_byte_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic int pick_field_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(0, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(256, 258);
    endfunction

    function automatic logic [31:0] pick_bitstream_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(0, 10);
        else if (r < 85)
            return $urandom();
        return $urandom_range(11, 40);
    endfunction

    // One random file. A broken file has either a wrong key in one keyed
    // field or is cut short before the next file starts.
    task automatic send_random_file(input bit well_formed);
        int          bad_field;
        int          len;
        int          payload_count;
        logic [31:0] bit_len;
        logic [7:0]  key;
        open_file();
        bad_field = 7;
        if (!well_formed)
        begin
            if ($urandom_range(1) == 1)
                bad_field = $urandom_range(3, 6);
            else
                file_bytes_left = $urandom_range(1, 20);
        end
        for (int f = 0; f < 7; f++)
        begin
            if (f >= FIRST_KEYED_FIELD)
            begin
                key = KEY_B + 8'(f - 3);
                if (f == bad_field)
                begin
                    if ($urandom_range(1) == 1)
                        key = 8'($urandom_range(0, 255));
                    else
                        key = KEY_B + 8'($urandom_range(0, 3));
                    if (key == KEY_B + 8'(f - 3))
                        key = key ^ 8'h80;
                end
                put(key);
            end
            if (f < PAYLOAD_FIELD)
            begin
                len = pick_field_len();
                put(len[15:8]);
                put(len[7:0]);
                repeat (len) put(8'($urandom_range(0, 255)));
            end
            else
            begin
                bit_len = pick_bitstream_len();
                put(bit_len[31:24]);
                put(bit_len[23:16]);
                put(bit_len[15:8]);
                put(bit_len[7:0]);
                if (bit_len <= 32'd40)
                    payload_count = $urandom_range(0, bit_len + 4);
                else
                    payload_count = $urandom_range(0, 8);
                repeat (payload_count) put(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // A small legal file: zero-length and one-byte fields, two payload
    // bytes within the length and two beyond it.
    task automatic test_minimal_file();
        open_file();
        put(8'h00); put(8'h00);
        put(8'h00); put(8'h01); put(8'hA5);
        put(8'h00); put(8'h00);
        put(KEY_B); put(8'h00); put(8'h00);
        put(KEY_C); put(8'h00); put(8'h00);
        put(KEY_D); put(8'h00); put(8'h00);
        put(KEY_E); put(8'h00); put(8'h00); put(8'h00); put(8'h02);
        put(8'h5A); put(8'hFF);
        put(8'h00); put(8'h80);
    endtask

    // A wrong key sticks: the following bytes are ignored until a restart.
    task automatic test_bad_key();
        open_file();
        put(8'h00); put(8'h00);
        put(8'h00); put(8'h00);
        put(8'h00); put(8'h00);
        put(KEY_E);
        put(8'hFF);
        put(KEY_B);
    endtask

    // The largest field length, cut short by a restart, then a file with a
    // 256-byte body and a bitstream length near the top of its range.
    task automatic test_longest_fields();
        open_file();
        file_bytes_left = 22;
        put(8'hFF); put(8'hFF);
        repeat (20) put(8'($urandom_range(0, 255)));

        open_file();
        put(8'h01); put(8'h00);
        repeat (256) put(8'($urandom_range(0, 255)));
        put(8'h00); put(8'h00);
        put(8'h00); put(8'h00);
        put(KEY_B); put(8'h00); put(8'h00);
        put(KEY_C); put(8'h00); put(8'h01); put(8'h7E);
        put(KEY_D); put(8'h00); put(8'h00);
        put(KEY_E); put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFE);
        repeat (3) put(8'($urandom_range(0, 255)));
    endtask

    // The receiver stops for a long stretch while the sender keeps going,
    // so the block fills and stalls its input.
    task automatic test_result_backpressure();
        stall_hold_left = 120;
        send_random_file(1'b1);
        send_random_file(1'b1);
        drain_results();
    endtask

    // Mostly well-formed files, some broken ones, some loose noise bytes.
    task automatic test_random_files(input int send_pct, input int recv_pct,
                                     input int item_count);
        int stop_at;
        int r;
        sender_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = items_sent + item_count;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 75)
                send_random_file(1'b1);
            else if (r < 90)
                send_random_file(1'b0);
            else
                repeat ($urandom_range(1, 8))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(7) == 0);
        end
        drain_results();
    endtask

    // Receiver stall: a requested hold first, otherwise random.
    always @(negedge clk)
    begin
        if (stall_hold_left > 0)
        begin
            out_stall <= 1'b1;
            stall_hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_byte_results.size() == 0)
            begin
                $error("unexpected result item: out_byte 0x%0h", out_byte);
                fail_count++;
            end
            else
            begin
                want = pending_byte_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("out_byte", 32'(want.out_byte), 32'(out_byte));
                check_field("field_number", 32'(want.field_number), 32'(field_number));
                check_field("remaining_length", want.remaining_length, remaining_length);
                check_field("extra_count", want.extra_count, extra_count);
            end
        end
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("bitstream_header_stripper regression: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_idle_pct = 22;
        recv_idle_pct = 47;
        test_minimal_file();
        test_bad_key();
        drain_results();
        test_result_backpressure();
        test_random_files(22, 47, 160);
        test_random_files(47, 22, 160);
        test_random_files(0, 0, 160);
        test_longest_fields();
        drain_results();

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_byte_results.size() == 0)
            $display("bitstream_header_stripper regression: pass");
        else
            $display("bitstream_header_stripper regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bhs_pkg.sv
sv/bhs_parser.sv
sv/bitstream_header_stripper.sv
tb/bitstream_header_stripper_tb.sv
